/* hw/rtl/dpvd_pkg.sv */
package dpvd_pkg;

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    // field selector codes
    localparam logic [1:0] FLD_DAY   = 2'd0;
    localparam logic [1:0] FLD_MONTH = 2'd1;
    localparam logic [1:0] FLD_YEAR  = 2'd2;

    // queue between parser and difference pipeline
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // one parsed date pair, ready for the difference step
    typedef struct packed {
        logic [1:0]  status;
        logic        err_second;
        logic [6:0]  first_day;
        logic [6:0]  first_month;
        logic [13:0] first_year;
        logic [6:0]  second_day;
        logic [6:0]  second_month;
        logic [13:0] second_year;
        logic        second_leap;
    } t_job;

endpackage

/* hw/rtl/dpvd_front.sv */
module dpvd_front
    import dpvd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char_code,
    output logic       o_push,
    output t_job       o_job
);

    logic        r_ds, n_ds;
    logic [1:0]  r_fs, n_fs;
    logic [2:0]  r_cnt, n_cnt;
    logic [13:0] r_acc, n_acc;
    logic [3:0]  r_dig [4];
    logic [3:0]  n_dig [4];
    logic [6:0]  r_d1, n_d1, r_m1, n_m1, r_d2, n_d2, r_m2, n_m2;
    logic [13:0] r_y1, n_y1;
    logic [1:0]  r_err, n_err;
    logic        r_edate, n_edate;

    logic        c_digit;
    logic [3:0]  c_val;
    logic        c_leap;
    logic [6:0]  c_d, c_m;
    logic [17:0] c_acc10;

    // keep the first error; a bad character overrides any other kind
    function automatic logic [2:0] note(input logic [1:0] cur, input logic cur_date,
                                        input logic [1:0] code, input logic ds);
        if (cur == ST_OK || (code == ST_BAD_CHAR && cur != ST_BAD_CHAR)) begin
            return {code, ds};
        end
        return {cur, cur_date};
    endfunction

    function automatic logic date_ok(input logic [6:0] d, input logic [6:0] m,
                                     input logic leap);
        logic [6:0] lim;
        lim = 7'd31;
        if (m == 7'd4 || m == 7'd6 || m == 7'd9 || m == 7'd11) begin
            lim = 7'd30;
        end else if (m == 7'd2) begin
            lim = leap ? 7'd29 : 7'd28;
        end
        return (m >= 7'd1) && (m <= 7'd12) && (d >= 7'd1) && (d <= lim);
    endfunction

    assign c_digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign c_val   = 4'(i_char_code - CH_ZERO);
    assign c_acc10 = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {14'd0, c_val};
    assign c_d     = r_ds ? r_d2 : r_d1;
    assign c_m     = r_ds ? r_m2 : r_m1;

    // decimal digits are kept, so century checks need no divider
    assign c_leap = (r_acc[1:0] == 2'b00) &&
                    ((r_dig[1] != 4'd0) || (r_dig[0] != 4'd0) ||
                     (r_dig[2][0] == 1'b0 && (r_dig[2][1] ^ r_dig[3][0]) == 1'b0));

    always_comb begin
        n_ds    = r_ds;
        n_fs    = r_fs;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_dig   = r_dig;
        n_d1    = r_d1;
        n_m1    = r_m1;
        n_y1    = r_y1;
        n_d2    = r_d2;
        n_m2    = r_m2;
        n_err   = r_err;
        n_edate = r_edate;
        o_push  = 1'b0;

        if (i_accept) begin
            if (c_digit) begin
                if (r_cnt < 3'd4) begin
                    n_acc    = c_acc10[13:0];
                    n_dig[3] = r_dig[2];
                    n_dig[2] = r_dig[1];
                    n_dig[1] = r_dig[0];
                    n_dig[0] = c_val;
                end
                if (r_cnt != 3'd7) begin
                    n_cnt = r_cnt + 3'd1;
                end
            end else if (i_char_code == CH_SLASH) begin
                if (r_fs >= FLD_YEAR) begin
                    {n_err, n_edate} = note(r_err, r_edate, ST_BAD_LEN, r_ds);
                end else begin
                    if (r_cnt < 3'd1 || r_cnt > 3'd2) begin
                        {n_err, n_edate} = note(r_err, r_edate, ST_BAD_LEN, r_ds);
                    end
                    if (r_fs == FLD_DAY) begin
                        if (r_ds) n_d2 = r_acc[6:0];
                        else      n_d1 = r_acc[6:0];
                    end else begin
                        if (r_ds) n_m2 = r_acc[6:0];
                        else      n_m1 = r_acc[6:0];
                    end
                    n_fs  = r_fs + 2'd1;
                    n_cnt = '0;
                    n_acc = '0;
                    n_dig = '{default: 4'd0};
                end
            end else if (i_char_code == CH_NL) begin
                if (r_fs != FLD_YEAR || (r_cnt != 3'd2 && r_cnt != 3'd4)) begin
                    {n_err, n_edate} = note(r_err, r_edate, ST_BAD_LEN, r_ds);
                end else if (!date_ok(c_d, c_m, c_leap)) begin
                    {n_err, n_edate} = note(r_err, r_edate, ST_RANGE, r_ds);
                end
                n_fs  = FLD_DAY;
                n_cnt = '0;
                n_acc = '0;
                n_dig = '{default: 4'd0};
                if (!r_ds) begin
                    n_y1 = r_acc;
                    n_ds = 1'b1;
                end else begin
                    // hand the pair over, then start clean
                    o_push  = 1'b1;
                    n_ds    = 1'b0;
                    n_d1    = '0;
                    n_m1    = '0;
                    n_y1    = '0;
                    n_d2    = '0;
                    n_m2    = '0;
                    n_err   = ST_OK;
                    n_edate = 1'b0;
                end
            end else begin
                {n_err, n_edate} = note(r_err, r_edate, ST_BAD_CHAR, r_ds);
            end
        end
    end

    // job fields use the error state as updated by the closing newline
    always_comb begin
        o_job.status       = ST_OK;
        o_job.err_second   = 1'b0;
        if (r_fs != FLD_YEAR || (r_cnt != 3'd2 && r_cnt != 3'd4)) begin
            {o_job.status, o_job.err_second} = note(r_err, r_edate, ST_BAD_LEN, r_ds);
        end else if (!date_ok(c_d, c_m, c_leap)) begin
            {o_job.status, o_job.err_second} = note(r_err, r_edate, ST_RANGE, r_ds);
        end else begin
            o_job.status     = r_err;
            o_job.err_second = r_edate;
        end
        o_job.first_day    = r_d1;
        o_job.first_month  = r_m1;
        o_job.first_year   = r_y1;
        o_job.second_day   = r_d2;
        o_job.second_month = r_m2;
        o_job.second_year  = r_acc;
        o_job.second_leap  = c_leap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ds    <= 1'b0;
            r_fs    <= FLD_DAY;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_dig   <= '{default: 4'd0};
            r_d1    <= '0;
            r_m1    <= '0;
            r_y1    <= '0;
            r_d2    <= '0;
            r_m2    <= '0;
            r_err   <= ST_OK;
            r_edate <= 1'b0;
        end else begin
            r_ds    <= n_ds;
            r_fs    <= n_fs;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_dig   <= n_dig;
            r_d1    <= n_d1;
            r_m1    <= n_m1;
            r_y1    <= n_y1;
            r_d2    <= n_d2;
            r_m2    <= n_m2;
            r_err   <= n_err;
            r_edate <= n_edate;
        end
    end

endmodule

/* hw/rtl/dpvd_fifo.sv */
module dpvd_fifo
    import dpvd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_nempty,
    output t_job o_job
);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt;
    logic           c_wr, c_rd;

    assign o_full   = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_job    = r_mem[r_rd];
    assign c_wr     = i_push && !o_full;
    assign c_rd     = i_pop && o_nempty;

    function automatic logic [QAW-1:0] bump(input logic [QAW-1:0] p);
        return (p == (QAW)'(QDEPTH - 1)) ? '0 : p + (QAW)'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (c_wr) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (c_wr) r_wr <= bump(r_wr);
            if (c_rd) r_rd <= bump(r_rd);
            if (c_wr && !c_rd)      r_cnt <= r_cnt + (QAW+1)'(1);
            else if (c_rd && !c_wr) r_cnt <= r_cnt - (QAW+1)'(1);
        end
    end

endmodule

/* hw/rtl/dpvd_back.sv */
module dpvd_back
    import dpvd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  t_job               i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic               o_error_in_second,
    output logic signed [14:0] o_diff_years,
    output logic [3:0]         o_diff_months,
    output logic [4:0]         o_diff_days
);

    // stage 1: day borrow
    logic        r_s1_v;
    logic [1:0]  r_s1_st;
    logic        r_s1_eds;
    logic [7:0]  r_s1_df;
    logic [6:0]  r_s1_di;
    logic [6:0]  r_s1_mf;
    logic [6:0]  r_s1_mi;
    logic [13:0] r_s1_yf;
    logic [13:0] r_s1_yi;

    // stage 2: output register
    logic        r_s2_v;
    logic [1:0]  r_s2_st;
    logic        r_s2_eds;
    logic [14:0] r_s2_dy;
    logic [3:0]  r_s2_dm;
    logic [4:0]  r_s2_dd;

    logic        c_s2_load, c_s1_load;
    logic        c_bd, c_bm;
    logic [7:0]  c_df;
    logic [6:0]  c_mf;
    logic [7:0]  c_mf12;
    logic [7:0]  c_dd;
    logic [7:0]  c_dm;
    logic [14:0] c_dy;

    // length of the month before m
    function automatic logic [4:0] prev_len(input logic [6:0] m, input logic leap);
        if (m == 7'd3) begin
            return leap ? 5'd29 : 5'd28;
        end else if (m == 7'd5 || m == 7'd7 || m == 7'd10 || m == 7'd12) begin
            return 5'd30;
        end
        return 5'd31;
    endfunction

    assign c_s2_load = !r_s2_v || !i_stall;
    assign c_s1_load = !r_s1_v || c_s2_load;
    assign o_pop     = i_job_valid && c_s1_load;

    assign c_bd = i_job.second_day < i_job.first_day;
    assign c_df = {1'b0, i_job.second_day} +
                  (c_bd ? {3'b000, prev_len(i_job.second_month, i_job.second_leap)} : 8'd0);
    assign c_mf = i_job.second_month - {6'd0, c_bd};

    assign c_bm   = r_s1_mf < r_s1_mi;
    assign c_mf12 = {1'b0, r_s1_mf} + (c_bm ? 8'd12 : 8'd0);
    assign c_dm   = c_mf12 - {1'b0, r_s1_mi};
    // saturate days at zero when the borrowed month is too short
    assign c_dd   = (r_s1_df < {1'b0, r_s1_di}) ? 8'd0 : r_s1_df - {1'b0, r_s1_di};
    assign c_dy   = {1'b0, r_s1_yf} - {1'b0, r_s1_yi} - {14'd0, c_bm};

    always_ff @(posedge i_clk) begin
        if (c_s1_load) begin
            r_s1_st  <= i_job.status;
            r_s1_eds <= i_job.err_second;
            r_s1_df  <= c_df;
            r_s1_di  <= i_job.first_day;
            r_s1_mf  <= c_mf;
            r_s1_mi  <= i_job.first_month;
            r_s1_yf  <= i_job.second_year;
            r_s1_yi  <= i_job.first_year;
        end
        if (c_s2_load) begin
            r_s2_st <= r_s1_st;
            if (r_s1_st == ST_OK) begin
                r_s2_eds <= 1'b0;
                r_s2_dy  <= c_dy;
                r_s2_dm  <= c_dm[3:0];
                r_s2_dd  <= c_dd[4:0];
            end else begin
                r_s2_eds <= r_s1_eds;
                r_s2_dy  <= '0;
                r_s2_dm  <= '0;
                r_s2_dd  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (c_s1_load) r_s1_v <= i_job_valid;
            if (c_s2_load) r_s2_v <= r_s1_v;
        end
    end

    assign o_valid           = r_s2_v;
    assign o_status          = r_s2_st;
    assign o_error_in_second = r_s2_eds;
    assign o_diff_years      = $signed(r_s2_dy);
    assign o_diff_months     = r_s2_dm;
    assign o_diff_days       = r_s2_dd;

endmodule

/* hw/rtl/date_parse_validate_difference_core.sv */
// Date pair parser and difference calculator. Feed ASCII characters of two
// dates, each day/month/year and closed by a newline; one character beat is
// taken every cycle while o_stall is low. After the second newline a single
// result beat carries the status (ok, bad character, bad field length, date
// out of range), which date held the error, and the years, months and days
// from the first date to the second. The result passes from the character
// parser through the queue and then the two difference pipeline stages (day
// borrow, output register). A two-entry queue sits between them, so the input
// stalls only when that queue is full while the output is held off. After
// each pair the parser is clean and ready for the next one.
module date_parse_validate_difference_core
    import dpvd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_code,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic               o_error_in_second,
    output logic signed [14:0] o_diff_years,
    output logic [3:0]         o_diff_months,
    output logic [4:0]         o_diff_days
);

    logic c_accept, c_push, c_pop, c_full, c_nempty;
    t_job c_job_in, c_job_out;

    assign o_stall  = c_full;
    assign c_accept = i_valid && !c_full;

    dpvd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (c_accept),
        .i_char_code (i_char_code),
        .o_push      (c_push),
        .o_job       (c_job_in)
    );

    dpvd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (c_push),
        .i_job    (c_job_in),
        .i_pop    (c_pop),
        .o_full   (c_full),
        .o_nempty (c_nempty),
        .o_job    (c_job_out)
    );

    dpvd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job_valid       (c_nempty),
        .i_job             (c_job_out),
        .o_pop             (c_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_error_in_second (o_error_in_second),
        .o_diff_years      (o_diff_years),
        .o_diff_months     (o_diff_months),
        .o_diff_days       (o_diff_days)
    );

endmodule

/* hw/rtl/dpvd_checker.sv */
module dpvd_checker
    import dpvd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [7:0]         i_char_code,
    input logic               o_valid,
    input logic               i_stall,
    input logic [1:0]         o_status,
    input logic               o_error_in_second,
    input logic signed [14:0] o_diff_years,
    input logic [3:0]         o_diff_months,
    input logic [4:0]         o_diff_days
);

    // hold a stalled character beat
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_char_code))
        else $error("character beat changed while stalled");

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_diff_years)
            && $stable(o_diff_months) && $stable(o_diff_days))
        else $error("result beat changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |->
            o_diff_years == 15'sd0 && o_diff_months == 4'd0 && o_diff_days == 5'd0)
        else $error("difference not cleared on error");

    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |->
            !o_error_in_second && o_diff_months <= 4'd11 && o_diff_days <= 5'd30)
        else $error("difference out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("busy after reset");

endmodule

bind date_parse_validate_difference_core dpvd_checker u_dpvd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .i_char_code       (i_char_code),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_status          (o_status),
    .o_error_in_second (o_error_in_second),
    .o_diff_years      (o_diff_years),
    .o_diff_months     (o_diff_months),
    .o_diff_days       (o_diff_days)
);
